/* rtl/route_bucket_rate_limiter_assert.svh */
// Assertion macros shared by the rate limiter modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ROUTE_BUCKET_RATE_LIMITER_ASSERT_SVH
`define ROUTE_BUCKET_RATE_LIMITER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define RBRL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rate limiter assertion failed");

// Next-cycle implication.
`define RBRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rate limiter assertion failed");

`else

`define RBRL_ASSERT_NOW(label, ante, cons)
`define RBRL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/rbrl_pkg.sv */
`timescale 1ns / 1ps

package rbrl_pkg;

    // Table geometry.
    localparam int ROUTE_SLOTS = 64;
    localparam int SLOT_AW     = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;

    // Field widths.
    localparam int FUNC_W   = 2;
    localparam int ROUTE_W  = 6;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int AFTER_W  = 24;
    localparam int DELAY_W  = 24;

    // Request kinds.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_UPDATE  = 2'd0,
        FUNC_CHECK   = 2'd1,
        FUNC_ACQUIRE = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    // One bucket as stored in the table memory.
    typedef struct packed {
        logic [COUNT_W-1:0] remaining;
        logic [COUNT_W-1:0] limit;
        logic [TIME_W-1:0]  deadline;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

/* rtl/rbrl_ram.sv */
`timescale 1ns / 1ps

module rbrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rbrl_ctrl.sv */
`timescale 1ns / 1ps
`include "route_bucket_rate_limiter_assert.svh"

module rbrl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output rbrl_pkg::ctrl_cmd_t cmd
);

    import rbrl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);

    // Next state: a request is read from the table while idle, then executed.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and result strobe registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_EXEC);
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign cmd.load = accept;
    assign cmd.exec = (state_reg == ST_EXEC);

    `RBRL_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == ST_EXEC)
    `RBRL_ASSERT_NEXT(a_exec_gives_done, state_reg == ST_EXEC, done_reg && !busy)
    `RBRL_ASSERT_NOW(a_done_only_after_exec, done_reg, $past(state_reg) == ST_EXEC)

endmodule

/* rtl/rbrl_dp.sv */
`timescale 1ns / 1ps
`include "route_bucket_rate_limiter_assert.svh"

module rbrl_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rbrl_pkg::ctrl_cmd_t                 cmd,
    input  logic [rbrl_pkg::FUNC_W-1:0]         func,
    input  logic [rbrl_pkg::ROUTE_W-1:0]        route_index,
    input  logic [rbrl_pkg::TIME_W-1:0]         now_ms,
    input  logic [rbrl_pkg::COUNT_W-1:0]        hdr_remaining,
    input  logic [rbrl_pkg::COUNT_W-1:0]        hdr_limit,
    input  logic [rbrl_pkg::AFTER_W-1:0]        reset_after_ms,
    output logic                                allowed,
    output logic [rbrl_pkg::DELAY_W-1:0]        delay_ms
);

    import rbrl_pkg::*;

    // Captured request.
    func_t              func_reg;
    logic [ROUTE_W-1:0] route_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] lim_reg;
    logic [AFTER_W-1:0] after_reg;

    // Bucket valid marks and result registers.
    logic [ROUTE_SLOTS-1:0] valid_reg;
    logic [ROUTE_SLOTS-1:0] valid_next;
    logic                   allowed_reg;
    logic                   allowed_next;
    logic [DELAY_W-1:0]     delay_reg;
    logic [DELAY_W-1:0]     delay_next;

    // Table access.
    logic [SLOT_AW-1:0] rd_addr;
    logic [SLOT_AW-1:0] slot_addr;
    logic [ENTRY_W-1:0] rd_data;
    entry_t             entry;
    entry_t             wr_entry;
    logic               wr_en;

    // Arithmetic on the stored bucket.
    logic               in_table;
    logic               known;
    logic [TIME_W-1:0]  since_deadline;
    logic [TIME_W-1:0]  left_ms;
    logic               passed;
    logic               has_remaining;

    // The table read is issued with the incoming route, so data is ready in EXEC.
    assign rd_addr   = SLOT_AW'(route_index);
    assign slot_addr = SLOT_AW'(route_reg);

    rbrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROUTE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (slot_addr),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign entry = entry_t'(rd_data);

    // Capture the request when it is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func_t'(func);
            route_reg <= route_index;
            now_reg   <= now_ms;
            rem_reg   <= hdr_remaining;
            lim_reg   <= hdr_limit;
            after_reg <= reset_after_ms;
        end
    end

    // Deadline tests use the signed difference of wrapping times.
    assign in_table       = 32'(route_reg) < 32'(ROUTE_SLOTS);
    assign known          = in_table && valid_reg[slot_addr];
    assign since_deadline = now_reg - entry.deadline;
    assign left_ms        = entry.deadline - now_reg;
    assign passed         = !since_deadline[TIME_W-1];
    assign has_remaining  = (entry.remaining != '0);

    // Request execution: table write-back, valid marks and the result.
    always_comb
    begin
        valid_next   = valid_reg;
        allowed_next = 1'b1;
        delay_next   = '0;
        wr_en        = 1'b0;
        wr_entry     = entry;
        if (cmd.exec)
        begin
            case (func_reg)
                FUNC_UPDATE:
                begin
                    if (in_table)
                    begin
                        wr_en                = 1'b1;
                        wr_entry.remaining   = rem_reg;
                        wr_entry.limit       = lim_reg;
                        wr_entry.deadline    = now_reg + TIME_W'(after_reg);
                        valid_next[slot_addr] = 1'b1;
                    end
                end
                FUNC_CHECK:
                begin
                    if (known)
                    begin
                        if (passed)
                        begin
                            wr_en              = 1'b1;
                            wr_entry.remaining = entry.limit;
                        end
                        else
                        begin
                            allowed_next = has_remaining;
                        end
                    end
                end
                FUNC_ACQUIRE:
                begin
                    if (known && !passed)
                    begin
                        if (has_remaining)
                        begin
                            wr_en              = 1'b1;
                            wr_entry.remaining = entry.remaining - COUNT_W'(1);
                        end
                        else if (left_ms[TIME_W-1:DELAY_W] != '0)
                        begin
                            delay_next = '1;
                        end
                        else
                        begin
                            delay_next = left_ms[DELAY_W-1:0];
                        end
                    end
                end
                FUNC_CLEAR:
                begin
                    valid_next = '0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    // Valid marks clear on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result registers, loaded when a request executes.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            allowed_reg <= allowed_next;
            delay_reg   <= delay_next;
        end
    end

    assign allowed  = allowed_reg;
    assign delay_ms = delay_reg;

    `RBRL_ASSERT_NEXT(a_clear_empties, cmd.exec && (func_reg == FUNC_CLEAR), valid_reg == '0)
    `RBRL_ASSERT_NEXT(a_update_marks, cmd.exec && (func_reg == FUNC_UPDATE) && in_table, valid_reg[$past(slot_addr)])
    `RBRL_ASSERT_NEXT(a_delay_only_acquire, cmd.exec && (func_reg != FUNC_ACQUIRE), delay_reg == '0)
    `RBRL_ASSERT_NEXT(a_allowed_only_check, cmd.exec && (func_reg != FUNC_CHECK), allowed_reg)

endmodule

/* rtl/route_bucket_rate_limiter.sv */
`timescale 1ns / 1ps

// Per-route fixed-window rate limiter. Pulse start with a request while busy is
// low; the table entry for route_index is read in that cycle and updated in the
// next, and the answer appears on allowed and delay_ms for exactly one cycle
// with done high, after the request passes the EXEC state and the done register.
// The receiver cannot stall, so sample the result when done is high. A request
// is served by the registered read of the bucket table memory followed by its
// write-back; a new request can be taken in the same cycle that done is shown.
// Times wrap modulo 2^32 and deadlines compare by signed difference. After
// reset every route is unknown; clear (func 3) empties the table in one request.
module route_bucket_rate_limiter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rbrl_pkg::FUNC_W-1:0]   func,
    input  logic [rbrl_pkg::ROUTE_W-1:0]  route_index,
    input  logic [rbrl_pkg::TIME_W-1:0]   now_ms,
    input  logic [rbrl_pkg::COUNT_W-1:0]  hdr_remaining,
    input  logic [rbrl_pkg::COUNT_W-1:0]  hdr_limit,
    input  logic [rbrl_pkg::AFTER_W-1:0]  reset_after_ms,
    output logic                          done,
    output logic                          allowed,
    output logic [rbrl_pkg::DELAY_W-1:0]  delay_ms
);

    import rbrl_pkg::*;

    ctrl_cmd_t cmd;

    // Sequencing of requests.
    rbrl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Bucket table and request arithmetic.
    rbrl_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .func           (func),
        .route_index    (route_index),
        .now_ms         (now_ms),
        .hdr_remaining  (hdr_remaining),
        .hdr_limit      (hdr_limit),
        .reset_after_ms (reset_after_ms),
        .allowed        (allowed),
        .delay_ms       (delay_ms)
    );

endmodule
